[rtl/rect_pkg.sv]
// Shared constants, codes and types of the rectangle outline rasterizer.
`default_nettype none

package rect_pkg;

    localparam int CANVAS_SIZE = 64;
    localparam int ROW_W       = $clog2(CANVAS_SIZE);
    localparam int EXT_W       = $clog2(CANVAS_SIZE + 1);
    localparam int ACT_W       = 2;
    localparam int FIELD_W     = 8;
    localparam int CNT_W       = 16;
    localparam int USED_W      = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DRAW = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef logic [CANVAS_SIZE-1:0] t_row;

    typedef struct packed {
        logic             clr;
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        t_row             wr_data;
    } t_mem_req;

    typedef struct packed {
        logic valid;
        t_row data;
    } t_mem_rsp;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  drawn_count;
        logic              pixel;
        logic [USED_W-1:0] used_width;
        logic [USED_W-1:0] used_height;
    } t_result;

endpackage

`default_nettype wire

[rtl/rect_if.sv]
// Request and response channel interfaces of the rasterizer.
`default_nettype none

interface rect_in_if
    import rect_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] rect_width;
    logic [FIELD_W-1:0] rect_height;

    modport source (
        output valid, action, pos_x, pos_y, rect_width, rect_height,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, rect_width, rect_height,
        output ready
    );
endinterface

interface rect_out_if
    import rect_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [CNT_W-1:0]  drawn_count;
    logic              pixel;
    logic [USED_W-1:0] used_width;
    logic [USED_W-1:0] used_height;

    modport source (
        output valid, accepted, drawn_count, pixel, used_width, used_height,
        input  ready
    );
    modport sink (
        input  valid, accepted, drawn_count, pixel, used_width, used_height,
        output ready
    );
endinterface

`default_nettype wire

[rtl/rect_row_mem.sv]
// Canvas row memory with per-row valid bits and registered read.
`default_nettype none

module rect_row_mem
    import rect_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_req i_req,
    output t_mem_rsp      o_rsp
);

    t_row                   r_mem [CANVAS_SIZE];
    logic [CANVAS_SIZE-1:0] r_row_vld;
    t_row                   r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_row_vld[i_req.rd_addr];
        end
    end

    // a row never written since reset or clear reads back with valid low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_row_vld <= '0;
        end else if (i_req.wr_en) begin
            r_row_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rsp.valid = r_rd_vld;
    assign o_rsp.data  = r_rd_data;

endmodule

`default_nettype wire

[rtl/rect_seq.sv]
// Sequencer: decodes an action and walks the rows through the row update unit.
`default_nettype none

module rect_seq
    import rect_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rect_in_if.sink       i_req,
    output t_mem_req      o_mem_req,
    input  wire t_mem_rsp i_mem_rsp,
    output logic          o_res_valid,
    output t_result       o_res,
    input  wire logic     i_res_take
);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_x, n_x;
    logic [EXT_W-1:0]   r_xe, n_xe;
    logic [ROW_W-1:0]   r_y, n_y;
    logic [EXT_W-1:0]   r_ye, n_ye;
    logic [EXT_W-1:0]   r_rd_row, n_rd_row;
    logic               r_pend, n_pend;
    logic [ROW_W-1:0]   r_wr_row, n_wr_row;
    logic               r_wr_full, n_wr_full;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [EXT_W-1:0]   r_ext_x, n_ext_x;
    logic [EXT_W-1:0]   r_ext_y, n_ext_y;
    logic               r_acc, n_acc;
    logic               r_pix, n_pix;

    logic               in_fire;
    logic               origin_ok;
    logic               in_range;
    logic [FIELD_W:0]   sum_x, sum_y;
    logic [EXT_W-1:0]   clip_xe, clip_ye;
    logic [EXT_W-1:0]   x_ext, xe_last;
    logic               rows_left;
    t_row               full_mask, side_mask;

    assign in_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign origin_ok = (i_req.pos_x != '0) && (i_req.pos_y != '0)
                    && (i_req.pos_x < FIELD_W'(CANVAS_SIZE))
                    && (i_req.pos_y < FIELD_W'(CANVAS_SIZE));
    assign in_range  = (i_req.pos_x < FIELD_W'(CANVAS_SIZE))
                    && (i_req.pos_y < FIELD_W'(CANVAS_SIZE));

    // far edge = min(origin + size, canvas size)
    assign sum_x   = {1'b0, i_req.pos_x} + {1'b0, i_req.rect_width};
    assign sum_y   = {1'b0, i_req.pos_y} + {1'b0, i_req.rect_height};
    assign clip_xe = (sum_x > (FIELD_W+1)'(CANVAS_SIZE)) ? EXT_W'(CANVAS_SIZE)
                                                         : sum_x[EXT_W-1:0];
    assign clip_ye = (sum_y > (FIELD_W+1)'(CANVAS_SIZE)) ? EXT_W'(CANVAS_SIZE)
                                                         : sum_y[EXT_W-1:0];

    // row update unit: masks for the current rectangle
    assign x_ext   = EXT_W'(r_x);
    assign xe_last = r_xe - EXT_W'(1);

    always_comb begin
        for (int k = 0; k < CANVAS_SIZE; k++) begin
            full_mask[k] = (EXT_W'(k) >= x_ext) && (EXT_W'(k) < r_xe);
            side_mask[k] = (EXT_W'(k) == x_ext) || (EXT_W'(k) == xe_last);
        end
    end

    assign rows_left = (r_rd_row != r_ye);

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_xe      = r_xe;
        n_y       = r_y;
        n_ye      = r_ye;
        n_rd_row  = r_rd_row;
        n_pend    = 1'b0;
        n_wr_row  = r_wr_row;
        n_wr_full = r_wr_full;
        n_count   = r_count;
        n_ext_x   = r_ext_x;
        n_ext_y   = r_ext_y;
        n_acc     = r_acc;
        n_pix     = r_pix;
        o_mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_acc   = 1'b0;
                    n_pix   = 1'b0;
                    n_x     = i_req.pos_x[ROW_W-1:0];
                    n_y     = i_req.pos_y[ROW_W-1:0];
                    n_state = S_DONE;
                    case (i_req.action)
                        ACT_CLEAR: begin
                            o_mem_req.clr = 1'b1;
                            n_count = '0;
                            n_ext_x = '0;
                            n_ext_y = '0;
                        end
                        ACT_DRAW: begin
                            if (origin_ok) begin
                                n_acc    = 1'b1;
                                n_xe     = clip_xe;
                                n_ye     = clip_ye;
                                n_rd_row = EXT_W'(i_req.pos_y[ROW_W-1:0]);
                                if (r_count != CNT_MAX) begin
                                    n_count = r_count + CNT_W'(1);
                                end
                                if (clip_xe > r_ext_x) begin
                                    n_ext_x = clip_xe;
                                end
                                if (clip_ye > r_ext_y) begin
                                    n_ext_y = clip_ye;
                                end
                                // zero width or height marks nothing
                                if (i_req.rect_width != '0 && i_req.rect_height != '0) begin
                                    n_state = S_DRAW;
                                end
                            end
                        end
                        ACT_READ: begin
                            if (in_range) begin
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = i_req.pos_y[ROW_W-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAW: begin
                // read row r while writing back row r-1
                if (rows_left) begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = r_rd_row[ROW_W-1:0];
                    n_pend    = 1'b1;
                    n_wr_row  = r_rd_row[ROW_W-1:0];
                    n_wr_full = (r_rd_row == EXT_W'(r_y)) || (r_rd_row == r_ye - EXT_W'(1));
                    n_rd_row  = r_rd_row + EXT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
                if (r_pend) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = r_wr_row;
                    o_mem_req.wr_data = (i_mem_rsp.valid ? i_mem_rsp.data : '0)
                                      | (r_wr_full ? full_mask : side_mask);
                end
            end
            S_READ: begin
                n_pix   = i_mem_rsp.valid & i_mem_rsp.data[r_x];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_ext_x <= '0;
            r_ext_y <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_ext_x <= n_ext_x;
            r_ext_y <= n_ext_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_xe      <= n_xe;
        r_y       <= n_y;
        r_ye      <= n_ye;
        r_rd_row  <= n_rd_row;
        r_wr_row  <= n_wr_row;
        r_wr_full <= n_wr_full;
        r_acc     <= n_acc;
        r_pix     <= n_pix;
    end

    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.accepted    = r_acc;
    assign o_res.drawn_count = r_count;
    assign o_res.pixel       = r_pix;
    assign o_res.used_width  = USED_W'(r_ext_x);
    assign o_res.used_height = USED_W'(r_ext_y);

endmodule

`default_nettype wire

[rtl/rect_outline_rasterizer.sv]
// Top level of the rectangle outline rasterizer: sequencer, row memory, output register.
//
//  channel  | dir | payload                                              | handshake
//  ---------+-----+------------------------------------------------------+------------
//  i_req    | in  | action, pos_x, pos_y, rect_width, rect_height        | valid/ready
//  o_rsp    | out | accepted, drawn_count, pixel, used_width, used_height| valid/ready
//
// One item at a time. Clear, rejected or unused actions go straight to the
// result; a read first fetches its row, and a draw walks the clipped rows,
// one canvas row per cycle, through a single read/modify/write port pair.
// Reset and clear drop the row valid bits at once, so no clearing pass is needed.
// A stalled result sits in the output register; the next item may be accepted
// meanwhile, and its result waits in the sequencer until the register frees.
`default_nettype none

module rect_outline_rasterizer
    import rect_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rect_in_if.sink    i_req,
    rect_out_if.source o_rsp
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    logic     res_valid;
    t_result  res;
    logic     slot_free;
    logic     r_o_valid;
    t_result  r_o_res;

    rect_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem_req   (mem_req),
        .i_mem_rsp   (mem_rsp),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (slot_free)
    );

    rect_row_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    assign slot_free = !r_o_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (slot_free) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && res_valid) begin
            r_o_res <= res;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.accepted    = r_o_res.accepted;
    assign o_rsp.drawn_count = r_o_res.drawn_count;
    assign o_rsp.pixel       = r_o_res.pixel;
    assign o_rsp.used_width  = r_o_res.used_width;
    assign o_rsp.used_height = r_o_res.used_height;

`ifndef SYNTHESIS
    a_rw_diff_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("row read and write hit the same row");

    a_no_wr_on_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.clr |-> !mem_req.wr_en)
        else $error("row write during clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("new transaction taken while busy");

    a_acc_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.accepted) |-> (o_rsp.drawn_count != '0))
        else $error("accepted rectangle with zero count");

    a_extent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.used_width <= USED_W'(CANVAS_SIZE)
                         && o_rsp.used_height <= USED_W'(CANVAS_SIZE)))
        else $error("extent beyond canvas");
`endif

endmodule

`default_nettype wire

[tb/sv/rect_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the rasterizer: watches both channels, predicts each result and compares it.
module rect_checker
    import rect_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rect_in_if        i_req_mon,
    rect_out_if       i_rsp_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results,
    output int        o_draws_taken,
    output int        o_lit_reads
);

    // shadow copy of the block state
    t_row             plane [CANVAS_SIZE];
    logic [CNT_W-1:0] rect_total = '0;
    logic [USED_W-1:0] reach_x   = '0;
    logic [USED_W-1:0] reach_y   = '0;

    t_result result_q [$];
    int fails = 0;
    int seen = 0;
    int taken = 0;
    int lit = 0;

    initial begin
        foreach (plane[i]) plane[i] = '0;
    end

    task automatic apply_request(input logic [ACT_W-1:0] act,
                                 input logic [FIELD_W-1:0] px, py, wd, ht,
                                 output t_result res);
        int x, y, w, h;
        x = px;
        y = py;
        w = wd;
        h = ht;
        res = '0;
        case (act)
            ACT_CLEAR: begin
                foreach (plane[i]) plane[i] = '0;
                rect_total = '0;
                reach_x = '0;
                reach_y = '0;
            end
            ACT_DRAW: begin
                if (x > 0 && y > 0 && x < CANVAS_SIZE && y < CANVAS_SIZE) begin
                    if (x + w > CANVAS_SIZE) w = CANVAS_SIZE - x;
                    if (y + h > CANVAS_SIZE) h = CANVAS_SIZE - y;
                    res.accepted = 1'b1;
                    if (rect_total != CNT_MAX) rect_total = rect_total + 1'b1;
                    if (x + w > reach_x) reach_x = USED_W'(x + w);
                    if (y + h > reach_y) reach_y = USED_W'(y + h);
                    if (w > 0 && h > 0) begin
                        for (int r = y; r < y + h; r++) begin
                            if (r == y || r == y + h - 1) begin
                                for (int c = x; c < x + w; c++) plane[r][c] = 1'b1;
                            end else begin
                                plane[r][x] = 1'b1;
                                plane[r][x + w - 1] = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_READ: begin
                if (x < CANVAS_SIZE && y < CANVAS_SIZE) res.pixel = plane[y][x];
            end
            default: ;
        endcase
        res.drawn_count = rect_total;
        res.used_width  = reach_x;
        res.used_height = reach_y;
    endtask

    function automatic int field_bad(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            // request first: the response at this edge belongs to an older transaction
            if (i_req_mon.valid && i_req_mon.ready) begin
                apply_request(i_req_mon.action, i_req_mon.pos_x, i_req_mon.pos_y,
                              i_req_mon.rect_width, i_req_mon.rect_height, want);
                result_q.push_back(want);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got.accepted    = i_rsp_mon.accepted;
                got.drawn_count = i_rsp_mon.drawn_count;
                got.pixel       = i_rsp_mon.pixel;
                got.used_width  = i_rsp_mon.used_width;
                got.used_height = i_rsp_mon.used_height;
                if (result_q.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    seen++;
                    fails += field_bad("accepted", want.accepted, got.accepted);
                    fails += field_bad("drawn_count", want.drawn_count, got.drawn_count);
                    fails += field_bad("pixel", want.pixel, got.pixel);
                    fails += field_bad("used_width", want.used_width, got.used_width);
                    fails += field_bad("used_height", want.used_height, got.used_height);
                    if (want.accepted) taken++;
                    if (want.pixel) lit++;
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= result_q.size();
        o_results     <= seen;
        o_draws_taken <= taken;
        o_lit_reads   <= lit;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the rectangle outline rasterizer: clock, reset, stimulus and verdict.
module tb;
    import rect_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int RANDOM_ITEMS = 540;
    localparam int FLOOD_ITEMS  = 32;

    logic i_clk;
    logic i_rst_n;
    int unsigned cycle_cnt = 0;
    int req_quiet = 0;
    int rsp_quiet = 0;
    int fail_count, pending, results, draws_taken, lit_reads;
    logic [7:0] last_x = 8'd1;
    logic [7:0] last_y = 8'd1;
    logic [7:0] last_w = 8'd1;
    logic [7:0] last_h = 8'd1;

    rect_in_if  req_ch ();
    rect_out_if rsp_ch ();

    rect_outline_rasterizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    rect_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_ch),
        .i_rsp_mon     (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_draws_taken (draws_taken),
        .o_lit_reads   (lit_reads)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    // idle cycles before the next transaction; quiet stretches run with no idling
    function automatic int draw_idle(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic [7:0] px, py, wd, ht);
        int gap;
        gap = draw_idle(req_quiet);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.pos_x       <= px;
        req_ch.pos_y       <= py;
        req_ch.rect_width  <= wd;
        req_ch.rect_height <= ht;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_idle(rsp_quiet);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        int sel;
        logic [7:0] x, y, w, h;

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_CLEAR;
        req_ch.pos_x       <= '0;
        req_ch.pos_y       <= '0;
        req_ch.rect_width  <= '0;
        req_ch.rect_height <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners, clipping, rejects, degenerate sizes
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_DRAW, 8'd1, 8'd1, 8'd255, 8'd255);
        send_request(ACT_READ, 8'd1, 8'd1, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd63, 8'd1, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd1, 8'd63, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd63, 8'd63, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd32, 8'd32, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(ACT_READ, 8'd64, 8'd5, 8'd0, 8'd0);
        send_request(ACT_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(ACT_DRAW, 8'd0, 8'd5, 8'd3, 8'd3);
        send_request(ACT_DRAW, 8'd5, 8'd0, 8'd3, 8'd3);
        send_request(ACT_DRAW, 8'd64, 8'd5, 8'd3, 8'd3);
        send_request(ACT_DRAW, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(ACT_DRAW, 8'd5, 8'd5, 8'd0, 8'd10);
        send_request(ACT_DRAW, 8'd5, 8'd5, 8'd10, 8'd0);
        send_request(ACT_READ, 8'd5, 8'd5, 8'd0, 8'd0);
        send_request(ACT_DRAW, 8'd10, 8'd10, 8'd1, 8'd1);
        send_request(ACT_READ, 8'd10, 8'd10, 8'd0, 8'd0);
        send_request(ACT_DRAW, 8'd63, 8'd63, 8'd1, 8'd1);
        send_request(ACT_READ, 8'd63, 8'd63, 8'd0, 8'd0);
        send_request(ACT_UNUSED, 8'd63, 8'd63, 8'd255, 8'd255);
        send_request(ACT_DRAW, 8'd20, 8'd30, 8'd8, 8'd4);
        send_request(ACT_READ, 8'd27, 8'd31, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd23, 8'd31, 8'd0, 8'd0);

        // random traffic, mostly well-formed draws and reads aimed at the last outline
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                send_request(ACT_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (sel < 50) begin
                if ($urandom_range(0, 99) < 85) begin
                    x = 8'($urandom_range(1, 63));
                    y = 8'($urandom_range(1, 63));
                    case ($urandom_range(0, 19))
                        0: begin
                            w = 8'($urandom_range(0, 255));
                            h = 8'($urandom_range(0, 255));
                        end
                        1, 2, 3: begin
                            w = 8'($urandom_range(0, 63));
                            h = 8'($urandom_range(0, 63));
                        end
                        default: begin
                            w = 8'($urandom_range(0, 12));
                            h = 8'($urandom_range(0, 12));
                        end
                    endcase
                    last_x = x;
                    last_y = y;
                    last_w = w;
                    last_h = h;
                end else begin
                    x = 8'($urandom_range(0, 255));
                    y = 8'($urandom_range(0, 255));
                    w = 8'($urandom_range(0, 255));
                    h = 8'($urandom_range(0, 255));
                end
                send_request(ACT_DRAW, x, y, w, h);
            end else if (sel < 92) begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    case ($urandom_range(0, 2))
                        0: x = last_x;
                        1: x = last_x + last_w - 8'd1;
                        default: x = last_x + 8'($urandom_range(0, 2)) - 8'd1;
                    endcase
                    case ($urandom_range(0, 2))
                        0: y = last_y;
                        1: y = last_y + last_h - 8'd1;
                        default: y = last_y + 8'($urandom_range(0, 2)) - 8'd1;
                    endcase
                end else if (sel < 9) begin
                    x = 8'($urandom_range(0, 63));
                    y = 8'($urandom_range(0, 63));
                end else begin
                    x = 8'($urandom_range(0, 255));
                    y = 8'($urandom_range(0, 255));
                end
                send_request(ACT_READ, x, y, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            end else begin
                send_request(ACT_UNUSED, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            end
        end

        // burst of cheap degenerate draws, no idling on either side
        send_request(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        req_quiet = FLOOD_ITEMS + 16;
        rsp_quiet = FLOOD_ITEMS + 16;
        for (int n = 0; n < FLOOD_ITEMS; n++) begin
            x = 8'($urandom_range(1, 63));
            y = 8'($urandom_range(1, 63));
            if ($urandom_range(0, 1) == 0) begin
                w = 8'd0;
                h = 8'($urandom_range(0, 255));
            end else begin
                w = 8'($urandom_range(0, 255));
                h = 8'd0;
            end
            send_request(ACT_DRAW, x, y, w, h);
        end
        req_quiet = 0;
        rsp_quiet = 0;
        send_request(ACT_DRAW, 8'd2, 8'd2, 8'd5, 8'd5);
        send_request(ACT_DRAW, 8'd0, 8'd2, 8'd5, 8'd5);
        send_request(ACT_READ, 8'd2, 8'd2, 8'd0, 8'd0);
        send_request(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd2, 8'd2, 8'd0, 8'd0);

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results: %0d rectangles accepted, %0d reads of set cells.",
                 results, draws_taken, lit_reads);
        $display("Directed edges, random mixed traffic with stalls, and a back-to-back burst.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
